@@ design/spk_pkg.sv @@
// Shared types, constants and word functions for the Speck 48/96 cipher.
// No dependencies; used by the key schedule, the round cells and the top level.
`timescale 1ns / 1ps
`default_nettype none
package spk_pkg;

  localparam int WORD_W    = 24;
  localparam int ROUNDS    = 23;
  localparam int KEY_STEPS = 22;
  localparam int STEP_W    = $clog2(ROUNDS + 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    REG_KEY_WORD_0 = 2'd0,
    REG_KEY_WORD_1 = 2'd1,
    REG_KEY_WORD_2 = 2'd2,
    REG_KEY_WORD_3 = 2'd3
  } cfg_reg_t;

  // One block moving from cell to cell.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t ror8(input word_t v);
    return {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic word_t rol8(input word_t v);
    return {v[WORD_W-9:0], v[WORD_W-1:WORD_W-8]};
  endfunction

  function automatic word_t rol3(input word_t v);
    return {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

  function automatic word_t ror3(input word_t v);
    return {v[2:0], v[WORD_W-1:3]};
  endfunction

endpackage
`default_nettype wire

@@ design/speck48_96_block_cipher.sv @@
// Speck 48/96 block cipher top level: key schedule and a chain of 23 round cells.
// Each input block is registered in all 23 round cells in turn before m_tvalid
// shows it; one block per cycle while the output side does not stall the chain.
// After reset, and after every key register write, the key schedule runs with
// s_tready low until all round keys are made. Reset is synchronous and active high.
// Depends on spk_pkg, spk_key_sched and spk_round_cell.
`timescale 1ns / 1ps
`default_nettype none
module speck48_96_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // block_low [23:0], block_high [47:24]
  input  wire logic        s_tuser,   // kind: 0 encrypt, 1 decrypt
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // out_low [23:0], out_high [47:24]
  // Key register write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int R = spk_pkg::ROUNDS;

  logic                                  keys_ready;
  spk_pkg::word_t [R-1:0]                round_keys;
  spk_pkg::blk_t  [R:0]                  chain;
  logic                                  advance;

  // The whole chain moves forward together; it holds only when the last
  // cell carries a block that the output side has not taken yet.
  assign advance  = !chain[R].valid || m_tready;
  assign s_tready = advance && keys_ready;

  // The first link of the chain is fed straight from the input transfer.
  assign chain[0].valid = s_tvalid && s_tready;
  assign chain[0].kind  = spk_pkg::kind_t'(s_tuser);
  assign chain[0].x     = s_tdata[23:0];
  assign chain[0].y     = s_tdata[47:24];

  spk_key_sched u_key_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .keys_ready (keys_ready),
    .round_keys (round_keys)
  );

  // Cell i runs round i when encrypting and uses the keys in reverse
  // order when decrypting.
  for (genvar i = 0; i < R; i++) begin : g_cell
    spk_round_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (advance),
      .rk_enc  (round_keys[i]),
      .rk_dec  (round_keys[R-1-i]),
      .blk_in  (chain[i]),
      .blk_out (chain[i+1])
    );
  end

  // The last cell's registers serve as the output register.
  assign m_tvalid = chain[R].valid;
  assign m_tdata  = {chain[R].y, chain[R].x};

endmodule
`default_nettype wire

@@ design/spk_key_sched.sv @@
// Key registers and the iterative Speck key schedule, one step per cycle.
// Depends on spk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spk_key_sched (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [1:0]                           cfg_index,
  input  wire logic [spk_pkg::WORD_W-1:0]           cfg_data,
  output logic                                      keys_ready,
  output spk_pkg::word_t [spk_pkg::ROUNDS-1:0]      round_keys
);

  spk_pkg::word_t key_word_0, key_word_1, key_word_2, key_word_3;
  spk_pkg::word_t k_cur, l0, l1, l2;
  logic [spk_pkg::STEP_W-1:0] step;
  spk_pkg::word_t fresh, k_new, step_idx;

  // Step n (1..22) applies schedule index n-1 and produces round key n.
  assign step_idx = spk_pkg::word_t'(step - spk_pkg::STEP_W'(1));
  assign fresh    = (spk_pkg::ror8(l0) + k_cur) ^ step_idx;
  assign k_new    = spk_pkg::rol3(k_cur) ^ fresh;
  assign keys_ready = (step == spk_pkg::STEP_W'(spk_pkg::ROUNDS));

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word_0 <= '0;
      key_word_1 <= '0;
      key_word_2 <= '0;
      key_word_3 <= '0;
      step       <= '0;
    end else if (cfg_we) begin
      step <= '0;
      unique case (spk_pkg::cfg_reg_t'(cfg_index))
        spk_pkg::REG_KEY_WORD_0: key_word_0 <= cfg_data;
        spk_pkg::REG_KEY_WORD_1: key_word_1 <= cfg_data;
        spk_pkg::REG_KEY_WORD_2: key_word_2 <= cfg_data;
        spk_pkg::REG_KEY_WORD_3: key_word_3 <= cfg_data;
        default: ;
      endcase
    end else if (step == '0) begin
      round_keys[0] <= key_word_0;
      k_cur         <= key_word_0;
      l0            <= key_word_1;
      l1            <= key_word_2;
      l2            <= key_word_3;
      step          <= step + spk_pkg::STEP_W'(1);
    end else if (!keys_ready) begin
      round_keys[step[spk_pkg::STEP_W-1:0]] <= k_new;
      k_cur <= k_new;
      l0    <= l1;
      l1    <= l2;
      l2    <= fresh;
      step  <= step + spk_pkg::STEP_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ design/spk_round_cell.sv @@
// One Speck round cell: a registered encrypt or decrypt round of one block.
// Depends on spk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module spk_round_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire spk_pkg::word_t rk_enc,
  input  wire spk_pkg::word_t rk_dec,
  input  wire spk_pkg::blk_t  blk_in,
  output spk_pkg::blk_t       blk_out
);

  spk_pkg::word_t x_enc, y_enc, x_dec, y_dec;

  assign x_enc = (spk_pkg::ror8(blk_in.x) + blk_in.y) ^ rk_enc;
  assign y_enc = spk_pkg::rol3(blk_in.y) ^ x_enc;
  assign y_dec = spk_pkg::ror3(blk_in.y ^ blk_in.x);
  assign x_dec = spk_pkg::rol8((blk_in.x ^ rk_dec) - y_dec);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_out.valid <= 1'b0;
    end else if (en) begin
      blk_out.valid <= blk_in.valid;
    end
    if (en) begin
      blk_out.kind <= blk_in.kind;
      if (blk_in.kind == spk_pkg::KIND_DEC) begin
        blk_out.x <= x_dec;
        blk_out.y <= y_dec;
      end else begin
        blk_out.x <= x_enc;
        blk_out.y <= y_enc;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/spk_checker.sv @@
// Port-level checks for the Speck 48/96 cipher, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module spk_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        cfg_we
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transfer changed");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input accepted while key schedule restarts");

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  a_ready_means_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(m_tvalid && !m_tready))
    else $error("input ready while output is stalled");

endmodule

bind speck48_96_block_cipher spk_checker u_spk_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .cfg_we   (cfg_we)
);
`default_nettype wire

@@ sim/tb_speck48_96_block_cipher.sv @@
// Self-checking testbench for the Speck 48/96 block cipher: a local cipher model
// predicts every output block, and random stalls on both streams stress the handshakes.
// Depends on spk_pkg and the speck48_96_block_cipher design sources.
`timescale 1ns / 1ps
module tb_speck48_96_block_cipher;

  typedef struct packed {
    spk_pkg::word_t lo;  // out_low
    spk_pkg::word_t hi;  // out_high
  } cipher_out_t;

  localparam spk_pkg::word_t ALL_ONES = 24'hFFFFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;    // block_low [23:0], block_high [47:24]
  logic        s_tuser = 1'b0;  // kind: 0 encrypt, 1 decrypt
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // out_low [23:0], out_high [47:24]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  // Key registers as the block should hold them, and the blocks still owed.
  spk_pkg::word_t key_regs [4];
  cipher_out_t    pending_blocks [$];
  int             mismatch_count = 0;

  // Stall controls shared by the sender, the receiver and the test tasks.
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_hold_cycles = 0;

  speck48_96_block_cipher dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic spk_pkg::word_t rot_r(input spk_pkg::word_t v, input int n);
    return (v >> n) | (v << (spk_pkg::WORD_W - n));
  endfunction

  function automatic spk_pkg::word_t rot_l(input spk_pkg::word_t v, input int n);
    return (v << n) | (v >> (spk_pkg::WORD_W - n));
  endfunction

  function automatic spk_pkg::word_t rand_word();
    return spk_pkg::word_t'($urandom);
  endfunction

  // Expands the current key and runs the 23 rounds in the requested direction.
  function automatic cipher_out_t speck_predict(input spk_pkg::kind_t k,
                                                input spk_pkg::word_t x_in,
                                                input spk_pkg::word_t y_in);
    spk_pkg::word_t rk [spk_pkg::ROUNDS];
    spk_pkg::word_t lw [3];
    spk_pkg::word_t fresh;
    spk_pkg::word_t step;
    spk_pkg::word_t x;
    spk_pkg::word_t y;
    int             i;
    cipher_out_t    res;
    rk[0] = key_regs[spk_pkg::REG_KEY_WORD_0];
    lw[0] = key_regs[spk_pkg::REG_KEY_WORD_1];
    lw[1] = key_regs[spk_pkg::REG_KEY_WORD_2];
    lw[2] = key_regs[spk_pkg::REG_KEY_WORD_3];
    for (i = 0; i < spk_pkg::KEY_STEPS; i++) begin
      step = spk_pkg::word_t'(i);
      fresh = (rot_r(lw[0], 8) + rk[i]) ^ step;
      rk[i+1] = rot_l(rk[i], 3) ^ fresh;
      lw[0] = lw[1];
      lw[1] = lw[2];
      lw[2] = fresh;
    end
    x = x_in;
    y = y_in;
    if (k == spk_pkg::KIND_ENC) begin
      for (i = 0; i < spk_pkg::ROUNDS; i++) begin
        x = (rot_r(x, 8) + y) ^ rk[i];
        y = rot_l(y, 3) ^ x;
      end
    end else begin
      for (i = 0; i < spk_pkg::ROUNDS; i++) begin
        y = rot_r(y ^ x, 3);
        fresh = (x ^ rk[spk_pkg::ROUNDS-1-i]) - y;
        x = rot_l(fresh, 8);
      end
    end
    res.lo = x;
    res.hi = y;
    return res;
  endfunction

  // Mostly random words, with zero, all ones and single-bit patterns mixed in.
  function automatic spk_pkg::word_t pick_word();
    spk_pkg::word_t w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = ALL_ONES;
      2: w = spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WORD_W - 1);
      3: w = ~(spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WORD_W - 1));
      default: w = rand_word();
    endcase
    return w;
  endfunction

  // Offers one block and returns in the time step of its transfer. The valid
  // is left high so that a following block can go out on the very next edge.
  task automatic send_block(input spk_pkg::kind_t k, input spk_pkg::word_t lo,
                            input spk_pkg::word_t hi);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {hi, lo};
    do @(posedge clk); while (!s_tready);
    pending_blocks.push_back(speck_predict(k, lo, hi));
  endtask

  // Stops offering and waits until every owed block has come out.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  // Leaves cfg_we high; load_key lowers it after the last write.
  task automatic write_reg(input spk_pkg::cfg_reg_t r, input spk_pkg::word_t v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    key_regs[r] = v;
  endtask

  // Writes the key words selected by the mask; the block must be idle.
  task automatic load_key(input spk_pkg::word_t k0, input spk_pkg::word_t k1,
                          input spk_pkg::word_t k2, input spk_pkg::word_t k3,
                          input bit [3:0] which);
    quiesce();
    if (which[0]) write_reg(spk_pkg::REG_KEY_WORD_0, k0);
    if (which[1]) write_reg(spk_pkg::REG_KEY_WORD_1, k1);
    if (which[2]) write_reg(spk_pkg::REG_KEY_WORD_2, k2);
    if (which[3]) write_reg(spk_pkg::REG_KEY_WORD_3, k3);
    cfg_we <= 1'b0;
  endtask

  // Random blocks; about a quarter are followed by the inverse operation on the
  // predicted output, which should give the original block back.
  task automatic run_random_blocks(input int count);
    int             i;
    spk_pkg::kind_t k;
    spk_pkg::word_t lo;
    spk_pkg::word_t hi;
    cipher_out_t    res;
    i = 0;
    while (i < count) begin
      k  = ($urandom_range(0, 1) == 1) ? spk_pkg::KIND_DEC : spk_pkg::KIND_ENC;
      lo = pick_word();
      hi = pick_word();
      send_block(k, lo, hi);
      i++;
      if (i < count && $urandom_range(0, 3) == 0) begin
        res = speck_predict(k, lo, hi);
        send_block((k == spk_pkg::KIND_ENC) ? spk_pkg::KIND_DEC : spk_pkg::KIND_ENC,
                   res.lo, res.hi);
        i++;
      end
    end
  endtask

  // The all-zero key left by reset, with extreme and alternating blocks.
  task automatic test_reset_key();
    send_block(spk_pkg::KIND_ENC, 24'h000000, 24'h000000);
    send_block(spk_pkg::KIND_DEC, 24'h000000, 24'h000000);
    send_block(spk_pkg::KIND_ENC, ALL_ONES, ALL_ONES);
    send_block(spk_pkg::KIND_DEC, ALL_ONES, ALL_ONES);
    send_block(spk_pkg::KIND_ENC, 24'hAAAAAA, 24'h555555);
    send_block(spk_pkg::KIND_DEC, 24'h555555, 24'hAAAAAA);
    send_block(spk_pkg::KIND_ENC, 24'h000001, 24'h800000);
  endtask

  // The published Speck 48/96 vector, forward and back.
  task automatic test_known_vector();
    load_key(24'h020100, 24'h0A0908, 24'h121110, 24'h1A1918, 4'b1111);
    send_block(spk_pkg::KIND_ENC, 24'h6D2073, 24'h696874);
    send_block(spk_pkg::KIND_DEC, 24'h735E10, 24'hB6445D);
    send_block(spk_pkg::KIND_ENC, 24'h000000, 24'h000000);
    send_block(spk_pkg::KIND_DEC, ALL_ONES, 24'h000000);
  endtask

  // All-ones key, then key words 0 and 3 cleared one at a time to check each on its own.
  task automatic test_key_extremes();
    load_key(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 4'b1111);
    send_block(spk_pkg::KIND_ENC, 24'h000000, 24'h000000);
    send_block(spk_pkg::KIND_DEC, ALL_ONES, ALL_ONES);
    send_block(spk_pkg::KIND_ENC, 24'h123456, 24'hFEDCBA);
    load_key(24'h000000, 24'h0, 24'h0, 24'h0, 4'b0001);
    send_block(spk_pkg::KIND_ENC, ALL_ONES, 24'h000000);
    send_block(spk_pkg::KIND_DEC, 24'h000000, ALL_ONES);
    load_key(24'h0, 24'h0, 24'h0, 24'h000000, 4'b1000);
    send_block(spk_pkg::KIND_ENC, 24'h800001, 24'h7FFFFE);
    send_block(spk_pkg::KIND_DEC, 24'h800001, 24'h7FFFFE);
  endtask

  // The receiver holds off for a long stretch while blocks keep coming, so the
  // round pipeline fills and the input side has to stall.
  task automatic test_backpressure();
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), 4'b1111);
    tx_gaps = 1'b0;
    rx_hold_cycles = 400;
    run_random_blocks(80);
    tx_gaps = 1'b1;
  endtask

  // Several key settings, some with only a few words changed, some at the extremes.
  task automatic test_random_keys(input int phases, input int per_phase);
    int p;
    for (p = 0; p < phases; p++) begin
      case (p % 4)
        1: load_key(rand_word(), rand_word(), rand_word(), rand_word(),
                    4'($urandom_range(1, 15)));
        2: load_key($urandom_range(0, 1) ? ALL_ONES : 24'h0,
                    $urandom_range(0, 1) ? ALL_ONES : 24'h0,
                    $urandom_range(0, 1) ? ALL_ONES : 24'h0,
                    $urandom_range(0, 1) ? ALL_ONES : 24'h0, 4'b1111);
        default: load_key(rand_word(), rand_word(), rand_word(), rand_word(), 4'b1111);
      endcase
      run_random_blocks(per_phase);
    end
  endtask

  // Full rate on both sides for the last stretch.
  task automatic test_full_rate();
    load_key(rand_word(), rand_word(), rand_word(), rand_word(), 4'b1111);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random_blocks(110);
  endtask

  initial begin : stimulus
    key_regs[spk_pkg::REG_KEY_WORD_0] = '0;
    key_regs[spk_pkg::REG_KEY_WORD_1] = '0;
    key_regs[spk_pkg::REG_KEY_WORD_2] = '0;
    key_regs[spk_pkg::REG_KEY_WORD_3] = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_known_vector();
    test_key_extremes();
    test_backpressure();
    test_random_keys(7, 120);
    test_full_rate();
    quiesce();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** speck48_96_block_cipher: PASSED **");
    end else begin
      $display("** speck48_96_block_cipher: FAILED **");
    end
    $finish;
  end

  // Receiver pacing: ready bursts, random stall bursts, and the long hold-off.
  initial begin : rx_pace
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        rx_hold_cycles = 0;
      end else if (rx_gaps && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compares each output transfer with the oldest owed block.
  initial begin : result_check
    cipher_out_t    want;
    spk_pkg::word_t got_lo;
    spk_pkg::word_t got_hi;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got_lo = m_tdata[23:0];
        got_hi = m_tdata[47:24];
        if (pending_blocks.size() == 0) begin
          $error("output transfer with no block owed: out_low %h out_high %h",
                 got_lo, got_hi);
          mismatch_count++;
        end else begin
          want = pending_blocks.pop_front();
          if (got_lo !== want.lo) begin
            $error("out_low: expected %h, got %h", want.lo, got_lo);
            mismatch_count++;
          end
          if (got_hi !== want.hi) begin
            $error("out_high: expected %h, got %h", want.hi, got_hi);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("** speck48_96_block_cipher: FAILED **");
    $finish;
  end

endmodule
